// ===== hw/rtl/wle_pkg.sv =====
// ----------------------------------------------------------------------------
// wle_pkg
// shared types and key codes for the wrapped line editor
// ----------------------------------------------------------------------------
package wle_pkg;

    localparam logic [7:0] KEY_ERASE     = 8'h7F;
    localparam logic [7:0] KEY_KILL_LINE = 8'h15;
    localparam logic [7:0] KEY_KILL_WORD = 8'h17;
    localparam logic [7:0] KEY_FINISH    = 8'h04;
    localparam logic [7:0] KEY_CLEAR_ALL = 8'h01;
    localparam logic [7:0] PRINT_LO      = 8'd32;
    localparam logic [7:0] PRINT_HI      = 8'd126;
    localparam logic [7:0] CHAR_SPACE    = 8'd32;
    localparam logic [7:0] CTRL_BLANK_LO = 8'd9;
    localparam logic [7:0] CTRL_BLANK_HI = 8'd13;

    typedef logic [7:0] byte_t;
    typedef logic [8:0] count_t;
    typedef logic [3:0] rows_t;

    typedef enum logic [2:0] {
        OP_FINISH    = 3'd0,
        OP_ERASE     = 3'd1,
        OP_CLEAR_ALL = 3'd2,
        OP_KILL_LINE = 3'd3,
        OP_KILL_WORD = 3'd4,
        OP_PRINT     = 3'd5,
        OP_BELL      = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_ECHO      = 3'd1,
        ACT_BELL      = 3'd2,
        ACT_ERASE     = 3'd3,
        ACT_KILL_LINE = 3'd4,
        ACT_KILL_WORD = 3'd5,
        ACT_CLEAR_ALL = 3'd6,
        ACT_FINISH    = 3'd7
    } action_t;

    typedef struct packed {
        op_t   op;
        byte_t key;
    } cmd_t;

    typedef struct packed {
        action_t action;
        byte_t   echo_char;
        logic    line_wrapped;
        count_t  removed_count;
        rows_t   rows_moved;
        count_t  cursor_after;
        rows_t   row_after;
    } res_t;

endpackage

// ===== hw/rtl/wle_if.sv =====
// ----------------------------------------------------------------------------
// wle_if
// valid/ready channels for key words and result words
// ----------------------------------------------------------------------------
interface wle_key_if
    import wle_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t key_byte;

    modport source (output valid, output key_byte, input ready);
    modport sink (input valid, input key_byte, output ready);
endinterface

interface wle_res_if
    import wle_pkg::*;
();
    logic    valid;
    logic    ready;
    action_t action;
    byte_t   echo_char;
    logic    line_wrapped;
    count_t  removed_count;
    rows_t   rows_moved;
    count_t  cursor_after;
    rows_t   row_after;

    modport source (output valid, output action, output echo_char, output line_wrapped,
                    output removed_count, output rows_moved, output cursor_after,
                    output row_after, input ready);
    modport sink (input valid, input action, input echo_char, input line_wrapped,
                  input removed_count, input rows_moved, input cursor_after,
                  input row_after, output ready);
endinterface

// ===== hw/rtl/wrapped_line_editor_unit.sv =====
// ----------------------------------------------------------------------------
// wrapped_line_editor_unit
// console line-editing core with erase, kill line, word erase and clear all
// ----------------------------------------------------------------------------
// key: one key code per word, valid/ready. res: one result word per key.
// the front classifies each key and drops it into a two-entry queue, so key
// words keep being taken while the back end works or res is stalled.
// a plain key passes through a queue entry and then the result register, and
// the back end takes one key per cycle while res keeps up and no word erase walks.
// word erase walks back through the text store at one character per cycle,
// stopping at a non-blank after blanks or at the start of the store, and no
// other key is taken until its result is registered; the single store read
// port sets that rate.
// the result register holds its word while res.ready is low; the back end
// then stops popping and the queue fills, after which key.ready drops.
// reset clears the cursor, column, row and queue; the text store itself is
// not cleared, and only entries below the cursor are ever read.
// ----------------------------------------------------------------------------
module wrapped_line_editor_unit
    import wle_pkg::*;
#(
    parameter int LINE_WIDTH = 40,
    parameter int LINE_COUNT = 10
)
(
    input  logic      clk,
    input  logic      rst_n,
    wle_key_if.sink   key,
    wle_res_if.source res
);

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_pop_cmd;

    wle_front u_front (
        .key    (key),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_push_cmd)
    );

    wle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (q_pop_cmd)
    );

    wle_back #(
        .LINE_WIDTH (LINE_WIDTH),
        .LINE_COUNT (LINE_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .q_cmd   (q_pop_cmd),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

// ===== hw/rtl/wle_front.sv =====
// ----------------------------------------------------------------------------
// wle_front
// accepts key words and classifies them into editor commands
// ----------------------------------------------------------------------------
module wle_front
    import wle_pkg::*;
(
    wle_key_if.sink key,
    input  logic    q_full,
    output logic    q_push,
    output cmd_t    q_cmd
);

    op_t op;

    always_comb
    begin
        case (key.key_byte)
            KEY_FINISH:    op = OP_FINISH;
            KEY_ERASE:     op = OP_ERASE;
            KEY_CLEAR_ALL: op = OP_CLEAR_ALL;
            KEY_KILL_LINE: op = OP_KILL_LINE;
            KEY_KILL_WORD: op = OP_KILL_WORD;
            default:
            begin
                if (key.key_byte inside {[PRINT_LO:PRINT_HI]})
                    op = OP_PRINT;
                else
                    op = OP_BELL;
            end
        endcase
    end

    assign key.ready = !q_full;
    assign q_push    = key.valid && !q_full;
    assign q_cmd     = '{op: op, key: key.key_byte};

endmodule

// ===== hw/rtl/wle_queue.sv =====
// ----------------------------------------------------------------------------
// wle_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module wle_queue
    import wle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_cmd
);

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_cmd   = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = !wr_ptr_reg;
        if (pop)
            rd_ptr_next = !rd_ptr_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== hw/rtl/wle_back.sv =====
// ----------------------------------------------------------------------------
// wle_back
// executes editor commands against the text store and registers results
// ----------------------------------------------------------------------------
module wle_back
    import wle_pkg::*;
#(
    parameter int LINE_WIDTH = 40,
    parameter int LINE_COUNT = 10
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    wle_res_if.source res
);

    localparam int DEPTH = LINE_WIDTH * LINE_COUNT;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int COLW  = $clog2(LINE_WIDTH);
    localparam int RW    = $clog2(LINE_COUNT + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cursor_reg, cursor_next;
    logic [COLW-1:0] col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [RW-1:0]   rcnt_reg, rcnt_next;
    logic            spaces_reg, spaces_next;
    logic            out_valid_reg, out_valid_next;
    res_t            res_reg, res_next;

    byte_t           store_mem [DEPTH];
    byte_t           rd_data_reg;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;

    logic            slot_free;
    logic            blank;
    logic [CW-1:0]   cur_dec;

    assign slot_free = !out_valid_reg || res.ready;
    assign blank     = rd_data_reg inside {CHAR_SPACE, [CTRL_BLANK_LO:CTRL_BLANK_HI]};
    assign cur_dec   = cursor_reg - CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        rem_next       = rem_reg;
        rcnt_next      = rcnt_reg;
        spaces_next    = spaces_reg;
        out_valid_next = out_valid_reg && !res.ready;
        res_next       = res_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = AW'(cur_dec);
        wr_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop                  = 1'b1;
                    res_next.action        = ACT_NONE;
                    res_next.echo_char     = '0;
                    res_next.line_wrapped  = 1'b0;
                    res_next.removed_count = '0;
                    res_next.rows_moved    = '0;
                    out_valid_next         = 1'b1;
                    case (q_cmd.op)
                        OP_FINISH:
                        begin
                            if (cursor_reg == '0)
                                res_next.action = ACT_FINISH;
                        end
                        OP_ERASE:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next            = cur_dec;
                                res_next.removed_count = count_t'(1);
                                res_next.action        = ACT_ERASE;
                                if (col_reg == '0)
                                begin
                                    col_next = COLW'(LINE_WIDTH - 1);
                                    if (row_reg != '0)
                                    begin
                                        row_next            = row_reg - RW'(1);
                                        res_next.rows_moved = rows_t'(1);
                                    end
                                end
                                else
                                    col_next = col_reg - COLW'(1);
                            end
                        end
                        OP_CLEAR_ALL:
                        begin
                            if (cursor_reg != '0)
                            begin
                                res_next.rows_moved = rows_t'({1'b0, row_reg} + 1'b1);
                                row_next            = '0;
                                cursor_next         = '0;
                                col_next            = '0;
                                res_next.action     = ACT_CLEAR_ALL;
                            end
                        end
                        OP_KILL_LINE:
                        begin
                            if (col_reg != '0)
                            begin
                                cursor_next            = cursor_reg - CW'(col_reg);
                                res_next.removed_count = count_t'(col_reg);
                                col_next               = '0;
                                res_next.action        = ACT_KILL_LINE;
                            end
                        end
                        OP_KILL_WORD:
                        begin
                            if (cursor_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                                rem_next       = '0;
                                rcnt_next      = '0;
                                spaces_next    = 1'b0;
                                rd_en          = 1'b1;
                                state_next     = ST_WALK;
                            end
                        end
                        OP_PRINT:
                        begin
                            if (cursor_reg < CW'(DEPTH))
                            begin
                                wr_en              = 1'b1;
                                cursor_next        = cursor_reg + CW'(1);
                                res_next.echo_char = q_cmd.key;
                                res_next.action    = ACT_ECHO;
                                if (col_reg == COLW'(LINE_WIDTH - 1))
                                begin
                                    col_next              = '0;
                                    row_next              = row_reg + RW'(1);
                                    res_next.line_wrapped = 1'b1;
                                end
                                else
                                    col_next = col_reg + COLW'(1);
                            end
                            else
                                res_next.action = ACT_BELL;
                        end
                        default:
                        begin
                            res_next.action = ACT_BELL;
                        end
                    endcase
                    res_next.cursor_after = count_t'(cursor_next);
                    res_next.row_after    = rows_t'(row_next);
                end
            end
            ST_WALK:
            begin
                if (!blank && spaces_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    spaces_next = spaces_reg || blank;
                    cursor_next = cur_dec;
                    rem_next    = rem_reg + CW'(1);
                    if (col_reg == '0)
                    begin
                        col_next = COLW'(LINE_WIDTH - 1);
                        if (row_reg != '0)
                        begin
                            row_next  = row_reg - RW'(1);
                            rcnt_next = rcnt_reg + RW'(1);
                        end
                    end
                    else
                        col_next = col_reg - COLW'(1);
                    if (cur_dec == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(cursor_reg - CW'(2));
                    end
                end
                if (state_next == ST_IDLE)
                begin
                    out_valid_next         = 1'b1;
                    res_next.action        = ACT_KILL_WORD;
                    res_next.echo_char     = '0;
                    res_next.line_wrapped  = 1'b0;
                    res_next.removed_count = count_t'(rem_next);
                    res_next.rows_moved    = rows_t'(rcnt_next);
                    res_next.cursor_after  = count_t'(cursor_next);
                    res_next.row_after     = rows_t'(row_next);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            rem_reg       <= '0;
            rcnt_reg      <= '0;
            spaces_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            rem_reg       <= rem_next;
            rcnt_reg      <= rcnt_next;
            spaces_reg    <= spaces_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[AW'(cursor_reg)] <= q_cmd.key;
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    assign res.valid         = out_valid_reg;
    assign res.action        = res_reg.action;
    assign res.echo_char     = res_reg.echo_char;
    assign res.line_wrapped  = res_reg.line_wrapped;
    assign res.removed_count = res_reg.removed_count;
    assign res.rows_moved    = res_reg.rows_moved;
    assign res.cursor_after  = res_reg.cursor_after;
    assign res.row_after     = res_reg.row_after;

    a_walk_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !out_valid_reg)
        else $error("result pending during word walk");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COLW'(LINE_WIDTH - 1))
        else $error("column out of range");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CW'(DEPTH))
        else $error("cursor beyond store");

    a_walk_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !q_pop)
        else $error("command taken during word walk");

    a_walk_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && state_next == ST_WALK) |=> (cursor_reg < $past(cursor_reg)))
        else $error("word walk did not move back");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives key words into the wrapped line editor and checks every result word
// against a line-editing predictor or a fixed expected word, with random idling on both channels
// ----------------------------------------------------------------------------
module testbench;
    import wle_pkg::*;

    localparam int LINE_W = 40;
    localparam int LINE_N = 10;
    localparam int DEPTH  = LINE_W * LINE_N;

    typedef struct {
        byte_t key;
        bit    typed;
        res_t  res;
    } step_row_t;

    logic clk;
    logic rst_n;

    wle_key_if key_ch ();
    wle_res_if res_ch ();

    wrapped_line_editor_unit #(
        .LINE_WIDTH(LINE_W),
        .LINE_COUNT(LINE_N)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .key(key_ch),
        .res(res_ch)
    );

    byte_t  text_mem [0:DEPTH-1];
    count_t text_len = '0;
    rows_t  row_now = '0;
    res_t   due_results [$];
    int     mismatches = 0;
    bit     key_calm = 1'b0;
    bit     res_calm = 1'b0;
    int     res_hold = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic res_t edit_key(input byte_t k);
        res_t  r;
        bit    spaces;
        byte_t ch;
        r = '0;
        r.action = ACT_NONE;
        if (k == KEY_FINISH)
        begin
            if (text_len == 0)
                r.action = ACT_FINISH;
        end
        else if (k == KEY_ERASE)
        begin
            if (text_len > 0)
            begin
                if (text_len % LINE_W == 0 && row_now > 0)
                begin
                    row_now--;
                    r.rows_moved = 4'd1;
                end
                text_len--;
                r.removed_count = 9'd1;
                r.action = ACT_ERASE;
            end
        end
        else if (k == KEY_CLEAR_ALL)
        begin
            if (text_len > 0)
            begin
                r.rows_moved = row_now + 4'd1;
                row_now = '0;
                text_len = '0;
                r.action = ACT_CLEAR_ALL;
            end
        end
        else if (k == KEY_KILL_LINE)
        begin
            if (text_len % LINE_W != 0)
            begin
                r.removed_count = count_t'(text_len % LINE_W);
                text_len = text_len - r.removed_count;
                r.action = ACT_KILL_LINE;
            end
        end
        else if (k == KEY_KILL_WORD)
        begin
            spaces = 1'b0;
            while (text_len > 0)
            begin
                ch = text_mem[text_len - 1];
                if (ch == CHAR_SPACE || (ch >= CTRL_BLANK_LO && ch <= CTRL_BLANK_HI))
                    spaces = 1'b1;
                else if (spaces)
                    break;
                text_len--;
                r.removed_count++;
                // stepping back over a line end
                if (text_len % LINE_W == LINE_W - 1 && row_now > 0)
                begin
                    row_now--;
                    r.rows_moved++;
                end
            end
            if (r.removed_count > 0)
                r.action = ACT_KILL_WORD;
        end
        else if (k >= PRINT_LO && k <= PRINT_HI)
        begin
            if (text_len < DEPTH)
            begin
                text_mem[text_len] = k;
                text_len++;
                r.echo_char = k;
                r.action = ACT_ECHO;
                if (text_len % LINE_W == 0)
                begin
                    r.line_wrapped = 1'b1;
                    row_now++;
                end
            end
            else
                r.action = ACT_BELL;
        end
        else
            r.action = ACT_BELL;
        r.cursor_after = text_len;
        r.row_after = row_now;
        return r;
    endfunction

    function automatic res_t fixed_res(input action_t a, input byte_t e, input count_t c);
        res_t r;
        r = '0;
        r.action = a;
        r.echo_char = e;
        r.cursor_after = c;
        return r;
    endfunction

    function automatic int key_gap();
        int pick;
        if (key_calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic byte_t mixed_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 48)
            return byte_t'($urandom_range(33, 126));
        if (pick < 62)
            return CHAR_SPACE;
        if (pick < 70)
            return KEY_ERASE;
        if (pick < 75)
            return KEY_KILL_LINE;
        if (pick < 83)
            return KEY_KILL_WORD;
        if (pick < 86)
            return KEY_CLEAR_ALL;
        if (pick < 89)
            return KEY_FINISH;
        if (pick < 94)
            return byte_t'($urandom_range(0, 31));
        return byte_t'($urandom_range(128, 255));
    endfunction

    // mostly words and spaces, so the store fills up
    function automatic byte_t fill_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 88)
            return byte_t'($urandom_range(33, 126));
        if (pick < 96)
            return CHAR_SPACE;
        if (pick < 98)
            return KEY_ERASE;
        return byte_t'($urandom_range(0, 255));
    endfunction

    task automatic send_key(input byte_t k, input bit typed, input res_t typed_res);
        int   gap;
        res_t want;
        gap = key_gap();
        if (gap > 0)
        begin
            key_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_ch.valid    <= 1'b1;
        key_ch.key_byte <= k;
        @(posedge clk);
        while (!key_ch.ready)
            @(posedge clk);
        want = edit_key(k);
        due_results.push_back(typed ? typed_res : want);
        if ($urandom_range(0, 99) < 3)
            key_calm = !key_calm;
    endtask

    task automatic cmp_field(input string what, input logic [8:0] want, input logic [8:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic check_word();
        res_t want;
        if (due_results.size() == 0)
        begin
            $display("%0t: result word with none expected, action %0d cursor %0d",
                     $time, res_ch.action, res_ch.cursor_after);
            mismatches++;
            return;
        end
        want = due_results.pop_front();
        cmp_field("action", want.action, res_ch.action);
        cmp_field("echo_char", want.echo_char, res_ch.echo_char);
        cmp_field("line_wrapped", want.line_wrapped, res_ch.line_wrapped);
        cmp_field("removed_count", want.removed_count, res_ch.removed_count);
        cmp_field("rows_moved", want.rows_moved, res_ch.rows_moved);
        cmp_field("cursor_after", want.cursor_after, res_ch.cursor_after);
        cmp_field("row_after", want.row_after, res_ch.row_after);
    endtask

    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_hold > 0)
            begin
                res_hold--;
                res_ch.ready <= 1'b0;
            end
            else if (!res_calm && $urandom_range(0, 99) < 20)
            begin
                res_hold = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 2)
                                                        : $urandom_range(9, 39);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                res_calm = !res_calm;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                check_word();
        end
    end

    initial
    begin
        step_row_t plan [$];
        key_ch.valid    <= 1'b0;
        key_ch.key_byte <= '0;
        rst_n           <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty line: every editing key does nothing, finish is reported
        plan.push_back('{KEY_FINISH,    1'b1, fixed_res(ACT_FINISH, 8'd0, 9'd0)});
        plan.push_back('{KEY_ERASE,     1'b1, fixed_res(ACT_NONE, 8'd0, 9'd0)});
        plan.push_back('{KEY_KILL_LINE, 1'b1, fixed_res(ACT_NONE, 8'd0, 9'd0)});
        plan.push_back('{KEY_KILL_WORD, 1'b1, fixed_res(ACT_NONE, 8'd0, 9'd0)});
        plan.push_back('{KEY_CLEAR_ALL, 1'b1, fixed_res(ACT_NONE, 8'd0, 9'd0)});
        plan.push_back('{8'h00,         1'b1, fixed_res(ACT_BELL, 8'd0, 9'd0)});
        plan.push_back('{8'hFF,         1'b1, fixed_res(ACT_BELL, 8'd0, 9'd0)});
        plan.push_back('{8'h80,         1'b1, fixed_res(ACT_BELL, 8'd0, 9'd0)});
        plan.push_back('{8'd31,         1'b1, fixed_res(ACT_BELL, 8'd0, 9'd0)});
        plan.push_back('{CHAR_SPACE,    1'b1, fixed_res(ACT_ECHO, CHAR_SPACE, 9'd1)});
        plan.push_back('{PRINT_HI,      1'b1, fixed_res(ACT_ECHO, PRINT_HI, 9'd2)});
        plan.push_back('{KEY_FINISH,    1'b1, fixed_res(ACT_NONE, 8'd0, 9'd2)});
        plan.push_back('{CTRL_BLANK_LO, 1'b1, fixed_res(ACT_BELL, 8'd0, 9'd2)});
        plan.push_back('{8'h21,         1'b0, '0});
        plan.push_back('{8'h61,         1'b0, '0});
        plan.push_back('{KEY_KILL_WORD, 1'b0, '0});
        plan.push_back('{8'h7A,         1'b0, '0});
        plan.push_back('{KEY_KILL_LINE, 1'b0, '0});
        plan.push_back('{8'h55,         1'b0, '0});
        plan.push_back('{KEY_ERASE,     1'b0, '0});
        plan.push_back('{8'hAA,         1'b0, '0});
        plan.push_back('{8'h41,         1'b0, '0});
        plan.push_back('{KEY_CLEAR_ALL, 1'b0, '0});
        plan.push_back('{8'h7E,         1'b0, '0});
        foreach (plan[i])
            send_key(plan[i].key, plan[i].typed, plan[i].res);

        repeat (40)
            send_key(mixed_key(), 1'b0, '0);

        // fill the whole store, wrapping through every row
        while (text_len < DEPTH)
            send_key(fill_key(), 1'b0, '0);
        repeat (3)
            send_key(byte_t'($urandom_range(33, 126)), 1'b0, '0);
        send_key(KEY_KILL_LINE, 1'b0, '0);
        send_key(KEY_ERASE, 1'b0, '0);
        send_key(byte_t'($urandom_range(33, 126)), 1'b0, '0);
        send_key(KEY_CLEAR_ALL, 1'b0, '0);

        repeat (30)
            send_key(mixed_key(), 1'b0, '0);
        key_ch.valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
